// ----- sv/gbn_pkg.sv -----
// Shared constants and codes for the go-back-N sender.
package gbn_pkg;

  localparam int SEQ_SPACE    = 8;
  localparam int SEQ_W        = $clog2(SEQ_SPACE);
  localparam int PAYLOAD_BITS = 32;
  localparam int KIND_W       = 2;
  localparam int EV_W         = 3;
  localparam int WIN_W        = 3;
  localparam int TMO_W        = 16;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 1;

  // input word kinds
  localparam logic [KIND_W-1:0] KIND_SEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  // result events
  localparam logic [EV_W-1:0] EV_SENT    = 3'd0;
  localparam logic [EV_W-1:0] EV_RESENT  = 3'd1;
  localparam logic [EV_W-1:0] EV_FULL    = 3'd2;
  localparam logic [EV_W-1:0] EV_ACK     = 3'd3;
  localparam logic [EV_W-1:0] EV_IGNORED = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  localparam logic [WIN_W-1:0] WINDOW_RESET  = 3'd4;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd3;

endpackage

// ----- sv/gbn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/go_back_n_sender.sv -----
// Go-back-N sender top level: window control, timer and frame store.
//
// Usage: an input word (send request, acknowledgement or timer tick) is
// taken on a rising edge with start high and busy low. Results appear on the
// out_ ports for one cycle each, flagged by out_valid; out_last marks the
// final result of an input word. The receiver cannot stall the block.
// The result of a send or an ack appears in the cycle after the word is
// taken; sends and acks leave busy low. A tick that does not expire gives
// no result. An expiring tick resends every outstanding frame, one per
// cycle starting the cycle after the tick, read from the frame store RAM;
// busy stays high until the last frame of the burst is on the ports.
// Configuration (window size, timeout) is written through cfg_we/cfg_index/
// cfg_wdata and takes effect at once; write it only while idle.
// Reset: base and next sequence numbers and the timer clear, the window
// returns to 4 and the timeout to 3 ticks. The frame store is not cleared;
// only entries written by a send are ever read back.
module go_back_n_sender (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [gbn_pkg::KIND_W-1:0]         in_kind,
  input  logic [gbn_pkg::PAYLOAD_BITS-1:0]   in_payload,
  input  logic [gbn_pkg::SEQ_W-1:0]          in_ack_seq,
  input  logic [gbn_pkg::SEQ_W-1:0]          in_ack_check,
  output logic                               out_valid,
  output logic [gbn_pkg::EV_W-1:0]           out_event_res,
  output logic [gbn_pkg::SEQ_W-1:0]          out_frame_seq,
  output logic [gbn_pkg::SEQ_W-1:0]          out_frame_check,
  output logic [gbn_pkg::PAYLOAD_BITS-1:0]   out_frame_payload,
  output logic [gbn_pkg::SEQ_W-1:0]          out_outstanding,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbn_pkg::CFG_W-1:0]          cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_BURST = 2'b10
  } state_t;

  localparam int SW = gbn_pkg::SEQ_W;
  localparam int PW = gbn_pkg::PAYLOAD_BITS;

  state_t                     state_r, state_nxt;
  logic [SW-1:0]              base_r, base_nxt;
  logic [SW-1:0]              next_r, next_nxt;
  logic [gbn_pkg::TMO_W-1:0]  timer_r, timer_nxt;
  logic [gbn_pkg::WIN_W-1:0]  window_r;
  logic [gbn_pkg::TMO_W-1:0]  timeout_r;
  logic [SW-1:0]              idx_r, idx_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [gbn_pkg::EV_W-1:0]   out_event_r, out_event_nxt;
  logic [SW-1:0]              out_seq_r, out_seq_nxt;
  logic [PW-1:0]              out_pay_r, out_pay_nxt;
  logic                       out_resend_r, out_resend_nxt;
  logic [SW-1:0]              out_outst_r, out_outst_nxt;
  logic                       out_last_r, out_last_nxt;

  logic                       accept;
  logic [SW-1:0]              outst;
  logic [gbn_pkg::WIN_W-1:0]  win;
  logic [SW-1:0]              ack_dist;
  logic [SW-1:0]              ack_base;
  logic [gbn_pkg::TMO_W-1:0]  limit;
  logic [gbn_pkg::TMO_W-1:0]  timer_inc;
  logic [SW-1:0]              rd_idx;
  logic [SW-1:0]              burst_idx;

  logic                       ram_we;
  logic [SW-1:0]              ram_raddr;
  logic [PW-1:0]              ram_rdata;

  gbn_ram #(
    .WIDTH (PW),
    .DEPTH (gbn_pkg::SEQ_SPACE)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (next_r),
    .wdata (in_payload),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && (state_r == ST_IDLE);

  assign outst     = next_r - base_r;
  assign win       = (window_r > gbn_pkg::WIN_W'(gbn_pkg::SEQ_SPACE - 1)) ?
                     gbn_pkg::WIN_W'(gbn_pkg::SEQ_SPACE - 1) : window_r;
  assign ack_dist  = in_ack_seq - base_r;
  assign ack_base  = in_ack_seq + SW'(1);
  assign limit     = (timeout_r == '0) ? gbn_pkg::TMO_W'(1) : timeout_r;
  assign timer_inc = (timer_r == '1) ? timer_r : timer_r + gbn_pkg::TMO_W'(1);
  assign burst_idx = idx_r + SW'(1);

  // read one entry ahead of the frame being shown
  assign rd_idx    = (state_r == ST_BURST) ? burst_idx : '0;
  assign ram_raddr = base_r + rd_idx;

  assign ram_we = accept && (in_kind == gbn_pkg::KIND_SEND) &&
                  ({{(gbn_pkg::WIN_W > SW ? gbn_pkg::WIN_W - SW : 0){1'b0}}, outst} < win);

  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    next_nxt       = next_r;
    timer_nxt      = timer_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = 1'b0;
    out_event_nxt  = out_event_r;
    out_seq_nxt    = out_seq_r;
    out_pay_nxt    = out_pay_r;
    out_resend_nxt = out_resend_r;
    out_outst_nxt  = out_outst_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            gbn_pkg::KIND_SEND: begin
              out_valid_nxt  = 1'b1;
              out_resend_nxt = 1'b0;
              out_last_nxt   = 1'b1;
              out_seq_nxt    = next_r;
              if (ram_we) begin
                out_event_nxt = gbn_pkg::EV_SENT;
                out_pay_nxt   = in_payload;
                out_outst_nxt = outst + SW'(1);
                next_nxt      = next_r + SW'(1);
                if (outst == '0) begin
                  timer_nxt = '0;
                end
              end else begin
                out_event_nxt = gbn_pkg::EV_FULL;
                out_pay_nxt   = '0;
                out_outst_nxt = outst;
              end
            end
            gbn_pkg::KIND_ACK: begin
              out_valid_nxt  = 1'b1;
              out_resend_nxt = 1'b0;
              out_last_nxt   = 1'b1;
              out_pay_nxt    = '0;
              if (in_ack_seq == in_ack_check && ack_dist < outst) begin
                base_nxt      = ack_base;
                timer_nxt     = '0;
                out_event_nxt = gbn_pkg::EV_ACK;
                out_seq_nxt   = ack_base;
                out_outst_nxt = next_r - ack_base;
              end else begin
                out_event_nxt = gbn_pkg::EV_IGNORED;
                out_seq_nxt   = base_r;
                out_outst_nxt = outst;
              end
            end
            gbn_pkg::KIND_TICK: begin
              if (outst == '0) begin
                timer_nxt = '0;
              end else if (timer_inc < limit) begin
                timer_nxt = timer_inc;
              end else begin
                // expiry: show the oldest frame next cycle, rest follow
                timer_nxt      = '0;
                out_valid_nxt  = 1'b1;
                out_resend_nxt = 1'b1;
                out_event_nxt  = gbn_pkg::EV_RESENT;
                out_seq_nxt    = base_r;
                out_outst_nxt  = outst;
                out_last_nxt   = (outst == SW'(1));
                idx_nxt        = '0;
                if (outst != SW'(1)) begin
                  state_nxt = ST_BURST;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_BURST: begin
        out_valid_nxt  = 1'b1;
        out_resend_nxt = 1'b1;
        out_event_nxt  = gbn_pkg::EV_RESENT;
        out_seq_nxt    = base_r + burst_idx;
        out_outst_nxt  = outst;
        out_last_nxt   = (burst_idx + SW'(1) == outst);
        idx_nxt        = burst_idx;
        if (burst_idx + SW'(1) == outst) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      timer_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      window_r    <= gbn_pkg::WINDOW_RESET;
      timeout_r   <= gbn_pkg::TIMEOUT_RESET;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      timer_r     <= timer_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          gbn_pkg::CFG_WINDOW:  window_r  <= cfg_wdata[gbn_pkg::WIN_W-1:0];
          gbn_pkg::CFG_TIMEOUT: timeout_r <= cfg_wdata[gbn_pkg::TMO_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_event_r  <= out_event_nxt;
    out_seq_r    <= out_seq_nxt;
    out_pay_r    <= out_pay_nxt;
    out_resend_r <= out_resend_nxt;
    out_outst_r  <= out_outst_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = out_event_r;
  assign out_frame_seq     = out_seq_r;
  assign out_frame_check   = out_seq_r;
  assign out_frame_payload = out_resend_r ? ram_rdata : out_pay_r;
  assign out_outstanding   = out_outst_r;
  assign out_last          = out_last_r;

endmodule
